// ===== design/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
package tle_pkg;

  localparam int ML_W       = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [ML_W-1:0] ML_RESET       = 6'd32;
  localparam logic            REG_MAX_LENGTH = 1'b0;

  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CTRL_U  = 8'h15;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  typedef enum logic [1:0] {
    ACT_ECHO    = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_END     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    SRC_BYTE,
    SRC_BRACKET,
    SRC_NEWLINE,
    SRC_ZERO,
    SRC_MEM
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ECHO,
    S_FULL_ERASE,
    S_ERASE_ONE,
    S_KILL,
    S_NEWLINE,
    S_DELIVER,
    S_END
  } state_t;

  typedef struct packed {
    logic    emit;
    action_t action;
    src_t    src;
    logic    last;
    logic    latch;
    logic    store;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    idx_clr;
    logic    idx_inc;
    logic    phase_wr;
    phase_t  phase_val;
  } cmd_t;

  typedef struct packed {
    logic   is_cr;
    logic   is_ctrl_u;
    logic   is_erase;
    logic   is_esc;
    logic   is_print;
    logic   is_bracket;
    logic   is_up_down;
    logic [1:0] phase;
    logic   count_zero;
    logic   count_one;
    logic   full;
    logic   deliver_last;
    logic   out_free;
  } sts_t;

endpackage

// ===== design/tle_datapath.sv =====
// Datapath of the terminal line editor: line memory, counters, escape phase and output register.
module tle_datapath #(
  parameter int LINE_SIZE = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tle_pkg::cmd_t             cmd,
  output tle_pkg::sts_t             sts,
  input  logic [7:0]                in_char_in,
  input  logic                      cfg_we,
  input  logic [tle_pkg::ML_W-1:0]  cfg_wdata,
  output logic [tle_pkg::ML_W-1:0]  max_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_action,
  output logic [7:0]                out_char_out,
  output logic                      out_last
);
  import tle_pkg::*;

  localparam int IDX_W = $clog2(LINE_SIZE);
  localparam logic [ML_W-1:0] CAP_LIMIT = ML_W'(LINE_SIZE - 1);

  logic [7:0]       mem [LINE_SIZE];
  logic [7:0]       byte_r;
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  phase_t           phase_r;
  logic [ML_W-1:0]  max_length_r;
  logic [ML_W-1:0]  cap_raw, cap;
  logic [7:0]       sel_char;
  logic             out_valid_r;
  logic [1:0]       out_action_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             out_free;

  assign cap_raw  = (max_length_r == '0) ? '0 : max_length_r - 1'b1;
  assign cap      = (cap_raw > CAP_LIMIT) ? CAP_LIMIT : cap_raw;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.src)
      SRC_BYTE:    sel_char = byte_r;
      SRC_BRACKET: sel_char = CH_BRACKET;
      SRC_NEWLINE: sel_char = CH_LF;
      SRC_MEM:     sel_char = rd_data_r;
      default:     sel_char = 8'h00;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    sts.is_cr        = (byte_r == CH_CR);
    sts.is_ctrl_u    = (byte_r == CH_CTRL_U);
    sts.is_erase     = (byte_r == CH_BS) || (byte_r == CH_DEL);
    sts.is_esc       = (byte_r == CH_ESC);
    sts.is_print     = (byte_r >= CH_SPACE) && (byte_r <= CH_TILDE);
    sts.is_bracket   = (byte_r == CH_BRACKET);
    sts.is_up_down   = (byte_r == CH_UP) || (byte_r == CH_DOWN);
    sts.phase        = phase_r;
    sts.count_zero   = (count_r == '0);
    sts.count_one    = (count_r == IDX_W'(1));
    sts.full         = (ML_W'(count_r) >= cap);
    sts.deliver_last = (IDX_W'(idx_r + 1'b1) == count_r);
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      phase_r      <= PH_NONE;
      max_length_r <= ML_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cmd.phase_wr) begin
        phase_r <= cmd.phase_val;
      end
      if (cfg_we) begin
        max_length_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r <= in_char_in;
    end
    if (cmd.emit) begin
      out_action_r <= cmd.action;
      out_char_r   <= sel_char;
      out_last_r   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count_r] <= sel_char;
    end
    rd_data_r <= mem[idx_nxt];
  end

  assign max_length   = max_length_r;
  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

// ===== design/tle_controller.sv =====
// Controller state machine of the terminal line editor.
module tle_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);
  import tle_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.phase_wr  = 1'b1;
        cmd.phase_val = PH_NONE;
        state_nxt     = S_IDLE;
        pend_nxt      = 1'b0;
        unique case (sts.phase)
          PH_ESC: begin
            if (sts.is_bracket) begin
              cmd.phase_val = PH_CSI;
            end else begin
              state_nxt = S_ECHO;
            end
          end
          PH_CSI: begin
            if (!sts.is_up_down) begin
              pend_nxt  = 1'b1;
              state_nxt = S_ECHO;
            end
          end
          default: begin
            if (sts.is_cr) begin
              state_nxt = S_NEWLINE;
            end else if (sts.is_ctrl_u) begin
              state_nxt = sts.count_zero ? S_IDLE : S_KILL;
            end else if (sts.is_erase) begin
              state_nxt = sts.count_zero ? S_IDLE : S_ERASE_ONE;
            end else if (sts.is_esc) begin
              cmd.phase_val = PH_ESC;
            end else if (sts.is_print) begin
              state_nxt = S_ECHO;
            end
          end
        endcase
      end
      S_ECHO: begin
        cmd.action = ACT_ECHO;
        cmd.src    = pend_r ? SRC_BRACKET : SRC_BYTE;
        cmd.last   = !sts.full && !pend_r;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.full) begin
            state_nxt = S_FULL_ERASE;
          end else begin
            cmd.store   = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (pend_r) begin
              pend_nxt = 1'b0;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_FULL_ERASE: begin
        cmd.action = ACT_ERASE;
        cmd.src    = SRC_ZERO;
        cmd.last   = !pend_r;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (pend_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_ECHO;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERASE_ONE: begin
        cmd.action = ACT_ERASE;
        cmd.src    = SRC_ZERO;
        cmd.last   = 1'b1;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_KILL: begin
        cmd.action = ACT_ERASE;
        cmd.src    = SRC_ZERO;
        cmd.last   = sts.count_one;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_dec = 1'b1;
          if (sts.count_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NEWLINE: begin
        cmd.action = ACT_ECHO;
        cmd.src    = SRC_NEWLINE;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.count_zero ? S_END : S_DELIVER;
        end
      end
      S_DELIVER: begin
        cmd.action = ACT_DELIVER;
        cmd.src    = SRC_MEM;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          if (sts.deliver_last) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        cmd.action = ACT_END;
        cmd.src    = SRC_ZERO;
        cmd.last   = 1'b1;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/terminal_line_editor.sv =====
// Terminal line editor: turns received terminal bytes into echo, erase, delivery and line-end transactions.
// Each received byte is taken in (S_IDLE) and decoded (S_DECODE), then each result transaction it
// causes is loaded into the output register when the output side does not stall; the next byte is
// taken once the last result has been loaded into the output register. A carriage return on a line
// of n stored chars gives n + 2 results; the line memory delivers one char per cycle, while the
// output does not stall, through its single registered read port. LINE_SIZE (2 to 62) sets
// the line memory depth; at most LINE_SIZE - 1 chars and at most max_length - 1 chars are stored.
// The max_length register lies at byte address 0 of the APB port and resets to 32.
module terminal_line_editor #(
  parameter int LINE_SIZE = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_action,
  output logic [7:0]                      out_char_out,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tle_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tle_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tle_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tle_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic            cfg_we;
  logic            reg_hit;
  logic [ML_W-1:0] max_length;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_MAX_LENGTH);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(max_length) : '0;

  tle_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tle_datapath #(
    .LINE_SIZE (LINE_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_char_in   (in_char_in),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[ML_W-1:0]),
    .max_length   (max_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_action   (out_action),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

// ===== design/tle_checker.sv =====
// Port-level checker for the terminal line editor and its bind statement.
module tle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_action,
  input logic [7:0] out_char_out,
  input logic       out_last
);
  import tle_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) && $stable(out_char_out)
      && $stable(out_last))
    else $error("stalled result changed");

  // After a byte is taken, the input stays stalled while it is decoded.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A line end is always the last result of its byte and carries no char.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_END) |-> out_last && (out_char_out == 8'h00))
    else $error("malformed line end");

  // Erase results carry no char.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_ERASE) |-> (out_char_out == 8'h00))
    else $error("erase carries a char");

  // A delivered char is never the last result of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_DELIVER) |-> !out_last)
    else $error("delivery marked last");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_action   (out_action),
  .out_char_out (out_char_out),
  .out_last     (out_last)
);
